### hw/rtl/lus_pkg.sv
package lus_pkg;

    localparam int MAX_SIZE = 8;
    localparam int IDX_W    = 3;
    localparam int ADDR_W   = 6;
    localparam int CNT_W    = 4;
    localparam int COPY_W   = 7;

    localparam logic [1:0] REQ_WR_MATRIX = 2'd0;
    localparam logic [1:0] REQ_WR_RHS    = 2'd1;
    localparam logic [1:0] REQ_SOLVE     = 2'd2;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_SINGULAR = 1'b1;

    localparam logic [3:0] SIZE_RESET = 4'd8;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [2:0]         row;
        logic [2:0]         col;
        logic signed [31:0] value;
    } t_in_word;

    typedef struct packed {
        logic [2:0]         index;
        logic signed [31:0] solution;
        logic               status;
        logic               last;
    } t_out_word;

    // Decoded request from the interface side to the solver core.
    typedef struct packed {
        logic               ld_a;
        logic               ld_b;
        logic               start;
        logic [2:0]         row;
        logic [2:0]         col;
        logic signed [31:0] value;
        logic [CNT_W-1:0]   size;
    } t_cmd;

    typedef struct packed {
        logic      idle;
        logic      emit;
        t_out_word word;
    } t_res;

    typedef enum logic [4:0] {
        S_IDLE, S_COPY, S_PV_RD, S_PV_CMP, S_SWAP,
        S_EL_RDN, S_EL_NUM, S_EL_DIV, S_EL_RDU, S_EL_RDA, S_EL_MUL, S_EL_WR,
        S_FW_RD, S_FW_MUL, S_FW_ACC, S_FW_WR,
        S_BK_RDD, S_BK_D, S_BK_RD, S_BK_MUL, S_BK_ACC, S_BK_Y, S_BK_DIV,
        S_OUT_RD, S_OUT, S_SING
    } t_state;

    // Q16.16 product scaled back, truncated toward zero.
    function automatic logic signed [63:0] qscale(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p[63] ? (p + 64'sd65535) : p;
        return t >>> 16;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > $signed(64'h0000_0000_7FFF_FFFF)) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < $signed(64'hFFFF_FFFF_8000_0000)) begin
            r = $signed(32'h8000_0000);
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

### hw/rtl/lus_ram.sv
module lus_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### hw/rtl/lus_div.sv
module lus_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_num,
    input  logic signed [31:0] i_den,
    output logic               o_done,
    output logic signed [31:0] o_quot
);
    import lus_pkg::*;

    localparam logic signed [63:0] NUM_LIMIT = 64'sd70368744177664;

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [5:0]         r_cnt, n_cnt;
    logic [32:0]        r_rem, n_rem;
    logic [62:0]        r_dvd, n_dvd;
    logic [62:0]        r_q, n_q;
    logic [31:0]        r_den, n_den;
    logic               r_neg, n_neg;

    logic signed [63:0] clamped;
    logic [63:0]        num_mag;
    logic [32:0]        rem_sh;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvd  = r_dvd;
        n_q    = r_q;
        n_den  = r_den;
        n_neg  = r_neg;
        rem_sh = {r_rem[31:0], r_dvd[62]};

        if (i_num > NUM_LIMIT) begin
            clamped = NUM_LIMIT;
        end else if (i_num < -NUM_LIMIT) begin
            clamped = -NUM_LIMIT;
        end else begin
            clamped = i_num;
        end
        num_mag = clamped[63] ? 64'(-clamped) : 64'(clamped);

        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 6'd0;
            n_rem  = '0;
            n_dvd  = {num_mag[46:0], 16'd0};
            n_q    = '0;
            n_den  = i_den[31] ? 32'(-i_den) : 32'(i_den);
            n_neg  = clamped[63] ^ i_den[31];
        end else if (r_busy) begin
            // One restoring step per cycle, 63 steps in all.
            if (rem_sh >= {1'b0, r_den}) begin
                n_rem = rem_sh - {1'b0, r_den};
                n_q   = {r_q[61:0], 1'b1};
            end else begin
                n_rem = rem_sh;
                n_q   = {r_q[61:0], 1'b0};
            end
            n_dvd = {r_dvd[61:0], 1'b0};
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd62) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        r_q   <= n_q;
        r_den <= n_den;
        r_neg <= n_neg;
    end

    always_comb begin
        if (!r_neg) begin
            o_quot = (r_q > 63'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(r_q[31:0]);
        end else begin
            o_quot = (r_q > 63'h8000_0000) ? $signed(32'h8000_0000)
                                           : $signed(32'(-r_q[31:0]));
        end
    end

    assign o_done = r_done;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy)
        else $error("divider did not start");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_cnt == 6'd62 && !i_start |=> r_done)
        else $error("divider missed its done pulse");
endmodule

### hw/rtl/lus_core.sv
module lus_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lus_pkg::t_cmd i_cmd,
    input  logic          i_out_free,
    output lus_pkg::t_res o_res
);
    import lus_pkg::*;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_k, n_k, r_i, n_i, r_j, n_j;
    logic [COPY_W-1:0]  r_cnt, n_cnt;
    logic [IDX_W-1:0]   r_perm [MAX_SIZE];
    logic [IDX_W-1:0]   n_perm [MAX_SIZE];
    logic [IDX_W-1:0]   r_piv, n_piv;
    logic [31:0]        r_best, n_best;
    logic signed [31:0] r_pv, n_pv, r_f, n_f, r_u, n_u, r_a, n_a, r_d, n_d;
    logic signed [63:0] r_prod, n_prod, r_acc, n_acc;
    logic [CNT_W-1:0]   r_n, n_n;

    logic               a_we;
    logic [ADDR_W-1:0]  a_waddr, a_raddr;
    logic [31:0]        a_rdata;
    logic               b_we;
    logic [IDX_W-1:0]   b_raddr;
    logic [31:0]        b_rdata;
    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr, w_raddr;
    logic [31:0]        w_wdata, w_rdata;
    logic               v_we;
    logic [IDX_W-1:0]   v_waddr, v_raddr;
    logic [31:0]        v_wdata, v_rdata;

    logic               div_start, div_done;
    logic signed [63:0] div_num;
    logic signed [31:0] div_den, div_quot;

    logic [31:0]        mag;
    logic [IDX_W-1:0]   ki, ii, ji, pk, pi;
    logic [CNT_W-1:0]   k1, i1, j1;
    logic [COPY_W-1:0]  cnt_m1;

    lus_ram #(.DEPTH(MAX_SIZE * MAX_SIZE), .WIDTH(32)) u_a_ram (
        .i_clk(i_clk), .i_we(a_we), .i_waddr(a_waddr), .i_wdata(i_cmd.value),
        .i_raddr(a_raddr), .o_rdata(a_rdata)
    );
    lus_ram #(.DEPTH(MAX_SIZE), .WIDTH(32)) u_b_ram (
        .i_clk(i_clk), .i_we(b_we), .i_waddr(i_cmd.row), .i_wdata(i_cmd.value),
        .i_raddr(b_raddr), .o_rdata(b_rdata)
    );
    lus_ram #(.DEPTH(MAX_SIZE * MAX_SIZE), .WIDTH(32)) u_w_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );
    lus_ram #(.DEPTH(MAX_SIZE), .WIDTH(32)) u_v_ram (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_waddr), .i_wdata(v_wdata),
        .i_raddr(v_raddr), .o_rdata(v_rdata)
    );

    lus_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start), .i_num(div_num),
        .i_den(div_den), .o_done(div_done), .o_quot(div_quot)
    );

    assign ki = r_k[IDX_W-1:0];
    assign ii = r_i[IDX_W-1:0];
    assign ji = r_j[IDX_W-1:0];
    assign pk = r_perm[ki];
    assign pi = r_perm[ii];
    assign k1 = r_k + CNT_W'(1);
    assign i1 = r_i + CNT_W'(1);
    assign j1 = r_j + CNT_W'(1);
    assign cnt_m1 = r_cnt - COPY_W'(1);
    assign mag = w_rdata[31] ? 32'(-w_rdata) : w_rdata;

    assign a_we    = i_cmd.ld_a;
    assign a_waddr = {i_cmd.row, i_cmd.col};
    assign b_we    = i_cmd.ld_b;

    always_comb begin
        n_state = r_state;
        n_k = r_k;  n_i = r_i;  n_j = r_j;  n_cnt = r_cnt;  n_n = r_n;
        n_perm = r_perm;
        n_piv = r_piv;  n_best = r_best;  n_pv = r_pv;  n_f = r_f;
        n_u = r_u;  n_a = r_a;  n_d = r_d;  n_prod = r_prod;  n_acc = r_acc;
        a_raddr = r_cnt[ADDR_W-1:0];
        b_raddr = pi;
        w_we = 1'b0;  w_waddr = {pi, ji};  w_wdata = w_rdata;  w_raddr = {pi, ji};
        v_we = 1'b0;  v_waddr = ii;  v_wdata = v_rdata;  v_raddr = ii;
        div_start = 1'b0;  div_num = '0;  div_den = r_pv;
        o_res.idle = (r_state == S_IDLE);
        o_res.emit = 1'b0;
        o_res.word = '{index: ii, solution: $signed(v_rdata), status: STATUS_OK,
                       last: (i1 == r_n)};

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.start) begin
                    for (int p = 0; p < MAX_SIZE; p++) begin
                        n_perm[p] = IDX_W'(p);
                    end
                    n_n = i_cmd.size;
                    n_cnt = '0;
                    n_state = S_COPY;
                end
            end
            S_COPY: begin
                // The read of entry cnt and the write of entry cnt-1 overlap.
                w_we = (r_cnt != '0);
                w_waddr = cnt_m1[ADDR_W-1:0];
                w_wdata = a_rdata;
                n_cnt = r_cnt + COPY_W'(1);
                if (r_cnt == COPY_W'(MAX_SIZE * MAX_SIZE)) begin
                    n_k = '0;
                    n_i = '0;
                    n_state = S_PV_RD;
                end
            end
            S_PV_RD: begin
                w_raddr = {pi, ki};
                n_state = S_PV_CMP;
            end
            S_PV_CMP: begin
                if (r_i == r_k || mag > r_best) begin
                    n_best = mag;
                    n_piv = ii;
                    n_pv = $signed(w_rdata);
                end
                n_i = i1;
                n_state = (i1 < r_n) ? S_PV_RD : S_SWAP;
            end
            S_SWAP: begin
                if (r_best == '0) begin
                    n_state = S_SING;
                end else begin
                    n_perm[ki] = r_perm[r_piv];
                    n_perm[r_piv] = r_perm[ki];
                    n_i = k1;
                    if (k1 < r_n) begin
                        n_state = S_EL_RDN;
                    end else begin
                        n_i = '0;
                        n_j = '0;
                        n_acc = '0;
                        n_state = S_FW_RD;
                    end
                end
            end
            S_EL_RDN: begin
                w_raddr = {pi, ki};
                n_state = S_EL_NUM;
            end
            S_EL_NUM: begin
                div_start = 1'b1;
                div_num = 64'($signed(w_rdata));
                div_den = r_pv;
                n_state = S_EL_DIV;
            end
            S_EL_DIV: begin
                if (div_done) begin
                    n_f = div_quot;
                    w_we = 1'b1;
                    w_waddr = {pi, ki};
                    w_wdata = div_quot;
                    n_j = k1;
                    n_state = S_EL_RDU;
                end
            end
            S_EL_RDU: begin
                if (r_j < r_n) begin
                    w_raddr = {pk, ji};
                    n_state = S_EL_RDA;
                end else if (i1 < r_n) begin
                    n_i = i1;
                    n_state = S_EL_RDN;
                end else begin
                    n_k = k1;
                    n_i = k1;
                    n_state = S_PV_RD;
                end
            end
            S_EL_RDA: begin
                n_u = $signed(w_rdata);
                w_raddr = {pi, ji};
                n_state = S_EL_MUL;
            end
            S_EL_MUL: begin
                n_a = $signed(w_rdata);
                n_prod = r_f * r_u;
                n_state = S_EL_WR;
            end
            S_EL_WR: begin
                w_we = 1'b1;
                w_waddr = {pi, ji};
                w_wdata = sat32(64'(r_a) - qscale(r_prod));
                n_j = j1;
                n_state = S_EL_RDU;
            end
            S_FW_RD: begin
                w_raddr = {pi, ji};
                v_raddr = ji;
                b_raddr = pi;
                n_state = (r_j < r_i) ? S_FW_MUL : S_FW_WR;
            end
            S_FW_MUL: begin
                n_prod = $signed(w_rdata) * $signed(v_rdata);
                n_state = S_FW_ACC;
            end
            S_FW_ACC: begin
                n_acc = r_acc + qscale(r_prod);
                n_j = j1;
                n_state = S_FW_RD;
            end
            S_FW_WR: begin
                v_we = 1'b1;
                v_waddr = ii;
                v_wdata = sat32(64'($signed(b_rdata)) - r_acc);
                n_j = '0;
                n_acc = '0;
                if (i1 < r_n) begin
                    n_i = i1;
                    n_state = S_FW_RD;
                end else begin
                    n_state = S_BK_RDD;
                end
            end
            S_BK_RDD: begin
                w_raddr = {pi, ii};
                n_state = S_BK_D;
            end
            S_BK_D: begin
                n_d = $signed(w_rdata);
                n_j = i1;
                n_acc = '0;
                n_state = S_BK_RD;
            end
            S_BK_RD: begin
                w_raddr = {pi, ji};
                v_raddr = (r_j < r_n) ? ji : ii;
                n_state = (r_j < r_n) ? S_BK_MUL : S_BK_Y;
            end
            S_BK_MUL: begin
                n_prod = $signed(w_rdata) * $signed(v_rdata);
                n_state = S_BK_ACC;
            end
            S_BK_ACC: begin
                n_acc = r_acc + qscale(r_prod);
                n_j = j1;
                n_state = S_BK_RD;
            end
            S_BK_Y: begin
                if (r_d == '0) begin
                    n_state = S_SING;
                end else begin
                    div_start = 1'b1;
                    div_num = 64'($signed(v_rdata)) - r_acc;
                    div_den = r_d;
                    n_state = S_BK_DIV;
                end
            end
            S_BK_DIV: begin
                if (div_done) begin
                    // The solution element replaces the forward result in place.
                    v_we = 1'b1;
                    v_waddr = ii;
                    v_wdata = div_quot;
                    if (r_i == '0) begin
                        n_state = S_OUT_RD;
                    end else begin
                        n_i = r_i - CNT_W'(1);
                        n_state = S_BK_RDD;
                    end
                end
            end
            S_OUT_RD: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_free) begin
                    o_res.emit = 1'b1;
                    if (i1 == r_n) begin
                        n_state = S_IDLE;
                    end else begin
                        n_i = i1;
                        n_state = S_OUT_RD;
                    end
                end
            end
            S_SING: begin
                o_res.word = '{index: '0, solution: '0, status: STATUS_SINGULAR,
                               last: 1'b1};
                if (i_out_free) begin
                    o_res.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            for (int p = 0; p < MAX_SIZE; p++) begin
                r_perm[p] <= IDX_W'(p);
            end
        end else begin
            r_state <= n_state;
            r_perm  <= n_perm;
        end
        r_k <= n_k;  r_i <= n_i;  r_j <= n_j;  r_cnt <= n_cnt;  r_n <= n_n;
        r_piv <= n_piv;  r_best <= n_best;  r_pv <= n_pv;  r_f <= n_f;
        r_u <= n_u;  r_a <= n_a;  r_d <= n_d;  r_prod <= n_prod;  r_acc <= n_acc;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.emit |-> i_out_free)
        else $error("word emitted into a full output stage");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.ld_a || i_cmd.ld_b || i_cmd.start) |-> r_state == S_IDLE)
        else $error("request taken while solving");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> (r_state == S_EL_NUM || r_state == S_BK_Y))
        else $error("divider started outside a divide step");
endmodule

### hw/rtl/lu_linear_solver.sv
// LU solver for A x = b, up to 8 by 8, signed Q16.16 with saturation.
// Input channel (i_in_valid / o_in_ready, i_in_word): a word either loads one
// element of A, loads one element of b, or starts a solve. Loads are accepted
// back to back while the solver is idle.
// A solve copies A into a work memory and factors it with partial pivoting,
// then runs forward and back substitution. Elimination updates and
// substitution steps work on the single work-memory read port, and each
// division runs in the one-bit-per-cycle divider.
// Output channel (o_out_valid / i_out_ready, o_out_word): n words with index
// 0..n-1, last set on the final one, or a single singular-status word.
// The output register lets the solver park the next word until the receiver
// takes the current one; a stalled receiver only holds the solver in place.
// Config channel (i_cfg_valid / o_cfg_ready, i_cfg_data) sets the size; write
// it only while idle. Reset sets size 8, identity row order and empty output.
module lu_linear_solver (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  lus_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output lus_pkg::t_out_word o_out_word,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [3:0]         i_cfg_data
);
    import lus_pkg::*;

    logic [3:0]  r_size;
    logic        r_out_valid;
    t_out_word   r_out_word;
    t_cmd        cmd;
    t_res        res;
    logic        in_acc;
    logic        out_free;
    logic [CNT_W-1:0] eff_size;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = res.idle;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        if (r_size == '0) begin
            eff_size = CNT_W'(1);
        end else if (r_size > 4'(MAX_SIZE)) begin
            eff_size = CNT_W'(MAX_SIZE);
        end else begin
            eff_size = r_size;
        end
        cmd.ld_a  = in_acc && (i_in_word.req_type == REQ_WR_MATRIX);
        cmd.ld_b  = in_acc && (i_in_word.req_type == REQ_WR_RHS);
        cmd.start = in_acc && (i_in_word.req_type == REQ_SOLVE);
        cmd.row   = i_in_word.row;
        cmd.col   = i_in_word.col;
        cmd.value = i_in_word.value;
        cmd.size  = eff_size;
    end

    lus_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_out_free(out_free),
        .o_res(res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size      <= SIZE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_size <= i_cfg_data;
            end
            if (res.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (res.emit) begin
            r_out_word <= res.word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status == STATUS_SINGULAR |-> o_out_word.last)
        else $error("singular word without last");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.start |=> !o_in_ready)
        else $error("solver still idle after a solve word");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.emit |=> o_out_valid)
        else $error("emitted word lost");
endmodule
